FILE: hdl/m3i_pkg.sv
// Shared widths, item types and queue status for the 3x3 matrix inverse core.
package m3i_pkg;
	// element format
	localparam int EW   = 32;
	localparam int FB   = 16;
	localparam int THRW = 31;
	localparam int NE   = 9;

	// cofactor, determinant and divider widths
	localparam int CW   = 2 * EW + 1;
	localparam int DTW  = 3 * EW + 3;
	localparam int ANW  = CW + 2 * FB;
	localparam int NW0  = (ANW + 1 > DTW) ? ANW + 1 : DTW;
	localparam int NW   = NW0 + 1;
	localparam int DW   = ((NW > DTW + 1) ? NW : DTW + 1) + 1;
	localparam int QB   = EW - 1;
	localparam int LAT  = QB + 3;

	// queue between front and back
	localparam int QD   = 4;
	localparam int QAW  = $clog2(QD);

	typedef logic signed [EW-1:0] elem_t;

	typedef struct packed {
		logic [NE-1:0][CW-1:0] cof;
		logic                  dsign;
		logic [DTW-1:0]        ad;
		logic                  sing;
	} m3i_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} m3i_qstat_t;
endpackage

FILE: hdl/m3i_front.sv
// Front pipeline: cofactors, determinant and singular classification.
module m3i_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  m3i_pkg::elem_t             m00,
	input  m3i_pkg::elem_t             m01,
	input  m3i_pkg::elem_t             m02,
	input  m3i_pkg::elem_t             m10,
	input  m3i_pkg::elem_t             m11,
	input  m3i_pkg::elem_t             m12,
	input  m3i_pkg::elem_t             m20,
	input  m3i_pkg::elem_t             m21,
	input  m3i_pkg::elem_t             m22,
	input  logic [m3i_pkg::THRW-1:0]   thr,
	output logic                       push,
	output m3i_pkg::m3i_item_t         item,
	input  m3i_pkg::m3i_qstat_t        qstat
);
	import m3i_pkg::*;

	// operand indices of each 2x2 minor: p*q - r*s
	localparam int unsigned PIDX [NE][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};

	elem_t                   mx [NE];
	logic [7:1]              vld_q;
	logic                    en;
	logic signed [2*EW-1:0]  pp0_s1 [NE];
	logic signed [2*EW-1:0]  pp1_s1 [NE];
	elem_t                   row0_s1 [3];
	logic signed [CW-1:0]    cof_s2 [NE];
	elem_t                   row0_s2 [3];
	logic signed [2*EW+1:0]  plo_s3 [3];
	logic signed [2*EW-1:0]  phi_s3 [3];
	logic signed [CW-1:0]    cof_s3 [NE];
	logic signed [DTW-1:0]   term_s4 [3];
	logic signed [CW-1:0]    cof_s4 [NE];
	logic signed [DTW-1:0]   det_s5;
	logic signed [CW-1:0]    cof_s5 [NE];
	logic [DTW-1:0]          ad_s6;
	logic                    dsign_s6;
	logic signed [CW-1:0]    cof_s6 [NE];
	logic [DTW-1:0]          ad_s7;
	logic                    dsign_s7;
	logic                    sing_s7;
	logic signed [CW-1:0]    cof_s7 [NE];
	logic [DTW-1:0]          lim;

	assign mx[0] = m00;
	assign mx[1] = m01;
	assign mx[2] = m02;
	assign mx[3] = m10;
	assign mx[4] = m11;
	assign mx[5] = m12;
	assign mx[6] = m20;
	assign mx[7] = m21;
	assign mx[8] = m22;

	// whole front advances unless the last stage is blocked by a full queue
	assign en       = !vld_q[7] || !qstat.full;
	assign in_stall = !en;
	assign push     = vld_q[7] && !qstat.full;
	assign lim      = DTW'({thr, {(2 * FB){1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[6:1], in_valid};
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NE; i++) begin
				pp0_s1[i] <= mx[PIDX[i][0]] * mx[PIDX[i][1]];
				pp1_s1[i] <= mx[PIDX[i][2]] * mx[PIDX[i][3]];
				cof_s2[i] <= CW'(pp0_s1[i]) - CW'(pp1_s1[i]);
				cof_s3[i] <= cof_s2[i];
				cof_s4[i] <= cof_s3[i];
				cof_s5[i] <= cof_s4[i];
				cof_s6[i] <= cof_s5[i];
				cof_s7[i] <= cof_s6[i];
			end
			for (int j = 0; j < 3; j++) begin
				row0_s1[j] <= mx[j];
				row0_s2[j] <= row0_s1[j];
				// row 0 entry times its cofactor, split into low and high halves
				plo_s3[j]  <= row0_s2[j] * $signed({1'b0, cof_s2[3 * j][EW:0]});
				phi_s3[j]  <= row0_s2[j] * $signed(cof_s2[3 * j][CW-1:EW+1]);
				term_s4[j] <= (DTW'(phi_s3[j]) <<< (EW + 1)) + DTW'(plo_s3[j]);
			end
			det_s5   <= term_s4[0] + term_s4[1] + term_s4[2];
			dsign_s6 <= det_s5[DTW-1];
			ad_s6    <= det_s5[DTW-1] ? (~det_s5 + 1'b1) : det_s5;
			dsign_s7 <= dsign_s6;
			ad_s7    <= ad_s6;
			sing_s7  <= (ad_s6 == '0) || (ad_s6 < lim);
		end
	end

	always_comb begin
		for (int i = 0; i < NE; i++) begin
			item.cof[i] = cof_s7[i];
		end
		item.dsign = dsign_s7;
		item.ad    = ad_s7;
		item.sing  = sing_s7;
	end
endmodule

FILE: hdl/m3i_queue.sv
// Short register queue between the front and back pipelines.
module m3i_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  m3i_pkg::m3i_item_t  push_item,
	input  logic                pop,
	output m3i_pkg::m3i_item_t  pop_item,
	output m3i_pkg::m3i_qstat_t qstat
);
	import m3i_pkg::*;

	m3i_item_t       mem_q [QD];
	logic [QAW-1:0]  wp_q;
	logic [QAW-1:0]  rp_q;
	logic [QAW:0]    cnt_q;
	logic            do_push;
	logic            do_pop;

	assign qstat.full  = (cnt_q == (QAW + 1)'(QD));
	assign qstat.empty = (cnt_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign pop_item    = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + 1'b1;
			if (do_pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW + 1)'(do_push) - (QAW + 1)'(do_pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= push_item;
		end
	end
endmodule

FILE: hdl/m3i_div.sv
// One pipelined divider lane: rounded, saturated cofactor / determinant.
module m3i_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [m3i_pkg::CW-1:0]      cof,
	input  logic                        dsign,
	input  logic [m3i_pkg::DTW-1:0]     ad,
	output m3i_pkg::elem_t              res
);
	import m3i_pkg::*;

	logic [CW-1:0]   mag_a;
	logic            neg_a;
	logic [DTW-1:0]  ad_a;
	logic [DW-1:0]   n_b;
	logic [DW-1:0]   d_b;
	logic            neg_b;
	logic [DW-1:0]   rem_s  [QB+1];
	logic [QB-1:0]   nlow_s [QB+1];
	logic [QB-1:0]   q_s    [QB+1];
	logic [DW-1:0]   d_s    [QB+1];
	logic            ovf_s  [QB+1];
	logic            neg_s  [QB+1];
	elem_t           qv;

	// magnitude, numerator 2*|cof|*2^2F + |det| over denominator 2*|det|
	always_ff @(posedge clk) begin
		if (en) begin
			mag_a     <= cof[CW-1] ? (~cof + 1'b1) : cof;
			neg_a     <= cof[CW-1] ^ dsign;
			ad_a      <= ad;
			n_b       <= DW'({mag_a, {(2 * FB){1'b0}}, 1'b0}) + DW'(ad_a);
			d_b       <= DW'({ad_a, 1'b0});
			neg_b     <= neg_a;
			// quotient of 2^(W-1) or more saturates
			ovf_s[0]  <= (n_b >> QB) >= d_b;
			rem_s[0]  <= n_b >> QB;
			nlow_s[0] <= n_b[QB-1:0];
			q_s[0]    <= '0;
			d_s[0]    <= d_b;
			neg_s[0]  <= neg_b;
		end
	end

	// one restoring step per stage
	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [DW:0] t;
		logic [DW:0] diff;
		logic        ge;

		assign t    = {rem_s[k], nlow_s[k][QB-1]};
		assign diff = t - {1'b0, d_s[k]};
		assign ge   = t >= {1'b0, d_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[DW-1:0] : t[DW-1:0];
				nlow_s[k+1] <= nlow_s[k] << 1;
				q_s[k+1]    <= {q_s[k][QB-2:0], ge};
				d_s[k+1]    <= d_s[k];
				ovf_s[k+1]  <= ovf_s[k];
				neg_s[k+1]  <= neg_s[k];
			end
		end
	end

	// sign and saturation
	assign qv = {1'b0, q_s[QB]};
	always_comb begin
		priority if (ovf_s[QB]) begin
			res = neg_s[QB] ? {1'b1, {(EW - 1){1'b0}}} : {1'b0, {(EW - 1){1'b1}}};
		end else if (neg_s[QB]) begin
			res = -qv;
		end else begin
			res = qv;
		end
	end
endmodule

FILE: hdl/m3i_back.sv
// Back pipeline: nine divider lanes, identity on singular items, output register.
module m3i_back (
	input  logic                clk,
	input  logic                arst_n,
	input  m3i_pkg::m3i_item_t  item,
	input  m3i_pkg::m3i_qstat_t qstat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output m3i_pkg::elem_t      res [m3i_pkg::NE],
	output logic                singular
);
	import m3i_pkg::*;

	logic            en;
	logic [LAT-1:0]  vld_q;
	logic [LAT-1:0]  sing_q;
	logic            out_valid_q;
	elem_t           lane_res [NE];
	elem_t           res_q [NE];
	logic            singular_q;

	assign en        = !out_valid_q || !out_stall;
	assign pop       = en && !qstat.empty;
	assign out_valid = out_valid_q;
	assign singular  = singular_q;
	assign res       = res_q;

	for (genvar i = 0; i < NE; i++) begin : g_lane
		m3i_div u_div (
			.clk   (clk),
			.en    (en),
			.cof   (item.cof[i]),
			.dsign (item.dsign),
			.ad    (item.ad),
			.res   (lane_res[i])
		);
	end

	// valid tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[LAT-2:0], pop};
			out_valid_q <= vld_q[LAT-1];
		end
	end

	// singular flag alongside the lanes, result mux into output register
	always_ff @(posedge clk) begin
		if (en) begin
			sing_q     <= {sing_q[LAT-2:0], item.sing};
			singular_q <= sing_q[LAT-1];
			for (int i = 0; i < NE; i++) begin
				if (sing_q[LAT-1]) begin
					res_q[i] <= (i % 4 == 0) ? (EW'(1) << FB) : '0;
				end else begin
					res_q[i] <= lane_res[i];
				end
			end
		end
	end
endmodule

FILE: hdl/matrix3x3_inverse_core.sv
// 3x3 matrix inverse by adjugate over determinant, Q16.16, top level.
// Throughput: one matrix per cycle unless stalled; 7 front stages, a 4-entry queue, then
// 34 stages of nine one-bit-per-stage divider lanes plus an output register.
// Reset: asynchronous, active low; clears valids and queue, threshold to 7.
// Pipeline data registers are not reset.
module matrix3x3_inverse_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [m3i_pkg::THRW-1:0]  cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  m3i_pkg::elem_t            m00,
	input  m3i_pkg::elem_t            m01,
	input  m3i_pkg::elem_t            m02,
	input  m3i_pkg::elem_t            m10,
	input  m3i_pkg::elem_t            m11,
	input  m3i_pkg::elem_t            m12,
	input  m3i_pkg::elem_t            m20,
	input  m3i_pkg::elem_t            m21,
	input  m3i_pkg::elem_t            m22,
	output logic                      out_valid,
	input  logic                      out_stall,
	output m3i_pkg::elem_t            r00,
	output m3i_pkg::elem_t            r01,
	output m3i_pkg::elem_t            r02,
	output m3i_pkg::elem_t            r10,
	output m3i_pkg::elem_t            r11,
	output m3i_pkg::elem_t            r12,
	output m3i_pkg::elem_t            r20,
	output m3i_pkg::elem_t            r21,
	output m3i_pkg::elem_t            r22,
	output logic                      singular
);
	import m3i_pkg::*;

	localparam logic [THRW-1:0] THR_RESET = THRW'(7);

	logic [THRW-1:0] thr_q;
	logic            push;
	logic            pop;
	m3i_item_t       f_item;
	m3i_item_t       b_item;
	m3i_qstat_t      qstat;
	elem_t           res [NE];

	// threshold register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	m3i_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.m00      (m00),
		.m01      (m01),
		.m02      (m02),
		.m10      (m10),
		.m11      (m11),
		.m12      (m12),
		.m20      (m20),
		.m21      (m21),
		.m22      (m22),
		.thr      (thr_q),
		.push     (push),
		.item     (f_item),
		.qstat    (qstat)
	);

	m3i_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (f_item),
		.pop       (pop),
		.pop_item  (b_item),
		.qstat     (qstat)
	);

	m3i_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (b_item),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res),
		.singular  (singular)
	);

	assign r00 = res[0];
	assign r01 = res[1];
	assign r02 = res[2];
	assign r10 = res[3];
	assign r11 = res[4];
	assign r12 = res[5];
	assign r20 = res[6];
	assign r21 = res[7];
	assign r22 = res[8];
endmodule

FILE: hdl/m3i_checker.sv
// Port-level checks for the matrix inverse core, bound to the top level.
module m3i_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_stall,
	input m3i_pkg::elem_t  r00,
	input m3i_pkg::elem_t  r01,
	input m3i_pkg::elem_t  r02,
	input m3i_pkg::elem_t  r10,
	input m3i_pkg::elem_t  r11,
	input m3i_pkg::elem_t  r12,
	input m3i_pkg::elem_t  r20,
	input m3i_pkg::elem_t  r21,
	input m3i_pkg::elem_t  r22,
	input logic            singular
);
	import m3i_pkg::*;

	localparam elem_t ONE = EW'(1) << FB;

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its diagonal entries and singular flag
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(r00) && $stable(r11) && $stable(r22)
			&& $stable(singular))
		else $error("result changed while stalled");

	// singular result carries ones on the diagonal
	a_sing_diag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> r00 == ONE && r11 == ONE && r22 == ONE)
		else $error("singular result diagonal not one");

	// singular result carries zeros off the diagonal
	a_sing_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> r01 == '0 && r02 == '0 && r10 == '0
			&& r12 == '0 && r20 == '0 && r21 == '0)
		else $error("singular result off-diagonal not zero");
endmodule

bind matrix3x3_inverse_core m3i_checker u_m3i_checker (.*);
